/* src/pia_pkg.sv */
// Package for the pixelwise image ALU: operation codes and default widths.
// No dependencies.
`default_nettype none
package pia_pkg;
	localparam int unsigned DataWidth = 32;
	localparam int unsigned FracBits  = 16;
	localparam int unsigned OpWidth   = 4;
	localparam int unsigned CfgIdxWidth = 2;

	typedef enum logic [OpWidth-1:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_ABSDIFF = 4'd4, OP_NORM = 4'd5, OP_MIN = 4'd6, OP_MAX = 4'd7,
		OP_LT = 4'd8, OP_GT = 4'd9, OP_EQ = 4'd10
	} op_t;

	typedef enum logic [CfgIdxWidth-1:0] {
		REG_OPERATION = 2'd0, REG_LEFT_IS_CONSTANT = 2'd1, REG_LEFT_CONSTANT = 2'd2
	} reg_idx_t;
endpackage
`default_nettype wire

/* src/pia_if.sv */
// Stream and configuration channel interfaces for the pixelwise image ALU.
// Depends on pia_pkg for the default data width and the register index width.
`default_nettype none
interface pia_pix_if #(parameter int unsigned DATA_WIDTH = pia_pkg::DataWidth);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] left_pixel;
	logic [DATA_WIDTH-1:0] right_pixel;
	modport source (output valid, left_pixel, right_pixel, input ready);
	modport sink (input valid, left_pixel, right_pixel, output ready);
endinterface

interface pia_res_if #(parameter int unsigned DATA_WIDTH = pia_pkg::DataWidth);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] result_pixel;
	logic                  saturated;
	modport source (output valid, result_pixel, saturated, input ready);
	modport sink (input valid, result_pixel, saturated, output ready);
endinterface

interface pia_cfg_if #(parameter int unsigned DATA_WIDTH = pia_pkg::DataWidth);
	logic                              valid;
	logic                              ready;
	logic [pia_pkg::CfgIdxWidth-1:0]   index;
	logic [DATA_WIDTH-1:0]             data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/pia_core.sv */
// Pipelined datapath of the pixelwise image ALU: operand prep, multiply,
// pipelined restoring divide and square root, result select and clip.
// Depends on pia_pkg.
`default_nettype none
module pia_core #(
	parameter int unsigned DATA_WIDTH = pia_pkg::DataWidth,
	parameter int unsigned FRAC_BITS  = pia_pkg::FracBits
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  in_valid,
	input  wire pia_pkg::op_t          op,
	input  wire logic [DATA_WIDTH-1:0] l_in,
	input  wire logic [DATA_WIDTH-1:0] r_in,
	output logic                       out_valid,
	output logic [DATA_WIDTH-1:0]      out_res,
	output logic                       out_sat
);
	localparam int unsigned W  = DATA_WIDTH;
	localparam int unsigned XW = W + 2;          // wide enough for add/sub/abs
	localparam int unsigned NW = W + FRAC_BITS;  // divide numerator width
	localparam int unsigned SW = 2 * W;          // sum of squares width, even for bit pairs
	localparam int unsigned QW = (SW + 1) / 2;   // square root width
	localparam int unsigned RW = W + 1;          // divide remainder width
	// Stages: prep, product, then NW divide steps overlapping QW root steps.
	localparam int unsigned DEPTH = (NW > QW ? NW : QW) + 1;
	localparam int unsigned MW  = 2 * W;

	typedef struct packed {
		logic               valid;
		pia_pkg::op_t       op;
		logic signed [XW-1:0] simple;   // add/sub/absdiff/min/max/compare value
		logic               sgn;
		logic               rzero;
		logic signed [XW-1:0] dz;      // divide-by-zero result
		logic [W-1:0]       lm;
		logic [W-1:0]       rm;
	} prep_t;

	prep_t s1;

	// Stage 1: operand magnitudes and the simple operations.
	logic signed [XW-1:0] lx, rx, simple_c, one_x;
	always_comb begin
		lx = XW'($signed(l_in));
		rx = XW'($signed(r_in));
		one_x = XW'(1) <<< FRAC_BITS;
		case (op)
			pia_pkg::OP_ADD:     simple_c = lx + rx;
			pia_pkg::OP_SUB:     simple_c = lx - rx;
			pia_pkg::OP_ABSDIFF: simple_c = (lx < rx) ? rx - lx : lx - rx;
			pia_pkg::OP_MIN:     simple_c = (lx < rx) ? lx : rx;
			pia_pkg::OP_MAX:     simple_c = (rx < lx) ? lx : rx;
			pia_pkg::OP_LT:      simple_c = (lx < rx) ? one_x : '0;
			pia_pkg::OP_GT:      simple_c = (rx < lx) ? one_x : '0;
			pia_pkg::OP_EQ:      simple_c = (lx == rx) ? one_x : '0;
			default:             simple_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1 <= '0;
		end else if (en) begin
			s1.valid  <= in_valid;
			s1.op     <= op;
			s1.simple <= simple_c;
			s1.sgn    <= l_in[W-1] ^ r_in[W-1];
			s1.rzero  <= (r_in == '0);
			s1.dz     <= (l_in == '0) ? '0 : (l_in[W-1] ? (XW'(-1) <<< (W-1)) : ~(XW'(-1) <<< (W-1)));
			s1.lm     <= l_in[W-1] ? W'(-l_in) : l_in;
			s1.rm     <= r_in[W-1] ? W'(-r_in) : r_in;
		end
	end

	// Stage 2: products. Squares and cross product, registered before use.
	logic [MW-1:0] prod_s2, sq_l_s2, sq_r_s2;
	prep_t s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2 <= '0;
		end else if (en) begin
			s2 <= s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2   <= s1.lm * s1.rm;
			sq_l_s2   <= s1.lm * s1.lm;
			sq_r_s2   <= s1.rm * s1.rm;
		end
	end

	// Pipeline of divide and root steps, one step per stage.
	typedef struct packed {
		logic               valid;
		pia_pkg::op_t       op;
		logic signed [XW-1:0] simple;
		logic               sgn;
		logic               rzero;
		logic signed [XW-1:0] dz;
		logic [MW-1:0]      prod;
		logic [W-1:0]       dvs;
		logic [NW-1:0]      num;   // numerator bits still to shift in, MSB first
		logic [RW-1:0]      rem;
		logic [NW-1:0]      quo;
		logic [SW-1:0]      rad;   // remaining radicand bits, top pair first
		logic [QW+1:0]      rrem;
		logic [QW-1:0]      root;
	} it_t;

	it_t st [DEPTH];

	// Entry: form numerator and sum of squares.
	it_t entry_c;
	always_comb begin
		entry_c.valid  = s2.valid;
		entry_c.op     = s2.op;
		entry_c.simple = s2.simple;
		entry_c.sgn    = s2.sgn;
		entry_c.rzero  = s2.rzero;
		entry_c.dz     = s2.dz;
		entry_c.prod   = prod_s2;
		entry_c.dvs    = s2.rm;
		entry_c.num    = NW'(s2.lm) << FRAC_BITS;
		entry_c.rem    = '0;
		entry_c.quo    = '0;
		entry_c.rad    = SW'(sq_l_s2) + SW'(sq_r_s2);
		entry_c.rrem   = '0;
		entry_c.root   = '0;
	end

	// One restoring divide step and one restoring root step per stage.
	function automatic it_t step(input it_t a, input int unsigned k);
		it_t b;
		logic [RW:0]   trial;
		logic [QW+3:0] rtrial;
		logic [QW+3:0] rcur;
		b = a;
		if (k < NW) begin
			trial = {a.rem, a.num[NW-1]} - (RW+1)'(a.dvs);
			b.num = a.num << 1;
			if (!trial[RW]) begin
				b.rem = trial[RW-1:0];
				b.quo = {a.quo[NW-2:0], 1'b1};
			end else begin
				b.rem = {a.rem[RW-2:0], a.num[NW-1]};
				b.quo = {a.quo[NW-2:0], 1'b0};
			end
		end
		if (k < QW) begin
			rcur   = {a.rrem, a.rad[SW-1 -: 2]};
			rtrial = rcur - {2'b00, a.root, 2'b01};
			b.rad  = a.rad << 2;
			if (!rtrial[QW+3]) begin
				b.rrem = rtrial[QW+1:0];
				b.root = {a.root[QW-2:0], 1'b1};
			end else begin
				b.rrem = rcur[QW+1:0];
				b.root = {a.root[QW-2:0], 1'b0};
			end
		end
		return b;
	endfunction

	for (genvar k = 0; k < DEPTH; k++) begin : g_iter
		it_t prev;
		if (k == 0) begin : g_first
			assign prev = entry_c;
		end else begin : g_next
			assign prev = step(st[k-1], k - 1);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				st[k] <= '0;
			end else if (en) begin
				st[k] <= prev;
			end
		end
	end

	// Final stage: select, sign and clip.
	it_t fin;
	localparam int unsigned CW = MW + 2;
	logic signed [CW-1:0] v_c, maxv, minv;
	logic                 dz_sat;
	always_comb begin
		fin  = st[DEPTH-1];
		maxv = ~(CW'(-1) <<< (W-1));
		minv = CW'(-1) <<< (W-1);
		dz_sat = 1'b0;
		case (fin.op)
			pia_pkg::OP_MUL: begin
				v_c = CW'(fin.prod >> FRAC_BITS);
				if (fin.sgn) v_c = -v_c;
			end
			pia_pkg::OP_DIV: begin
				if (fin.rzero) begin
					v_c = CW'(fin.dz);
					dz_sat = 1'b1;
				end else begin
					v_c = CW'(fin.quo);
					if (fin.sgn) v_c = -v_c;
				end
			end
			pia_pkg::OP_NORM: v_c = CW'(fin.root);
			default: v_c = CW'(fin.simple);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= fin.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (v_c > maxv) begin
				out_res <= maxv[W-1:0];
				out_sat <= 1'b1;
			end else if (v_c < minv) begin
				out_res <= minv[W-1:0];
				out_sat <= 1'b1;
			end else begin
				out_res <= v_c[W-1:0];
				out_sat <= dz_sat;
			end
		end
	end

`ifndef SYNTH
	// A divide by zero always flags saturation at the output.
	a_dz_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(en && fin.valid && fin.op == pia_pkg::OP_DIV && fin.rzero) |=> out_sat)
		else $error("divide by zero not flagged");
	// Less-than and equal comparisons never saturate when one is representable.
	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(en && fin.valid && (fin.op == pia_pkg::OP_LT || fin.op == pia_pkg::OP_EQ)
		 && FRAC_BITS < W - 1) |=> !out_sat)
		else $error("comparison flagged saturation");
	// A stall freezes the output stage.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(out_valid) && $stable(out_res))
		else $error("output moved during stall");
`endif
endmodule
`default_nettype wire

/* src/pixelwise_image_alu.sv */
// Top level of the pixelwise image ALU: configuration registers, stall control.
// Depends on pia_pkg, the channel interfaces and pia_core.
`default_nettype none
// Applies one configured operation to each pair of signed fixed-point pixels and
// returns one result per transaction, clipped to the word with a saturation flag.
// The datapath is a single pipeline that takes one transaction per clock unless
// stalled. Its depth is set by the restoring divider, which retires one
// quotient bit per stage, with the square root running alongside it.
// The whole pipeline stalls only when the output holds a result that is not
// taken. Configuration must be written idle.
module pixelwise_image_alu #(
	parameter int unsigned DATA_WIDTH = pia_pkg::DataWidth,
	parameter int unsigned FRAC_BITS  = pia_pkg::FracBits
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pia_cfg_if.sink   cfg,
	pia_pix_if.sink   pix,
	pia_res_if.source res
);
	logic [pia_pkg::OpWidth-1:0] operation_q;
	logic                        left_is_constant_q;
	logic [DATA_WIDTH-1:0]       left_constant_q;

	// Configuration register writes.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operation_q        <= '0;
			left_is_constant_q <= 1'b0;
			left_constant_q    <= '0;
		end else if (cfg.valid) begin
			unique case (pia_pkg::reg_idx_t'(cfg.index))
				pia_pkg::REG_OPERATION:        operation_q <= cfg.data[pia_pkg::OpWidth-1:0];
				pia_pkg::REG_LEFT_IS_CONSTANT: left_is_constant_q <= cfg.data[0];
				pia_pkg::REG_LEFT_CONSTANT:    left_constant_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// The pipeline advances unless the output holds an untaken result.
	logic en, out_valid;
	assign en        = !out_valid || res.ready;
	assign pix.ready = en;
	assign res.valid = out_valid;

	pia_core #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pix.valid),
		.op        (pia_pkg::op_t'(operation_q)),
		.l_in      (left_is_constant_q ? left_constant_q : pix.left_pixel),
		.r_in      (pix.right_pixel),
		.out_valid (out_valid),
		.out_res   (res.result_pixel),
		.out_sat   (res.saturated)
	);

`ifndef SYNTH
	// The input is held off while a result waits at the output.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |-> !pix.ready)
		else $error("input taken during output stall");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.valid && cfg.index == pia_pkg::REG_OPERATION) |=>
		operation_q == $past(cfg.data[pia_pkg::OpWidth-1:0]))
		else $error("operation register not written");
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> res.valid)
		else $error("result dropped");
`endif
endmodule
`default_nettype wire

/* verif/testbench.sv */
// Testbench for the pixelwise image ALU: directed table then random pixel pairs.
// Depends on pia_pkg, the channel interfaces and pixelwise_image_alu.
module testbench;
	localparam int unsigned Latency = pia_pkg::DataWidth + pia_pkg::FracBits + 4;
	localparam logic [31:0] WordMax = 32'h7fffffff;
	localparam logic [31:0] WordMin = 32'h80000000;
	localparam logic [31:0] OneQ = 32'h00010000;

	typedef struct packed {
		logic [31:0] value;
		logic        sat;
	} pix_result_t;

	typedef struct {
		logic [3:0]  op;
		logic        lic;
		logic [31:0] konst;
		logic [31:0] l;
		logic [31:0] r;
		logic        typed;
		logic [31:0] value;
		logic        sat;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pia_cfg_if cfg ();
	pia_pix_if pix ();
	pia_res_if res ();

	pixelwise_image_alu uut (.clk(clk), .arst_n(arst_n), .cfg(cfg), .pix(pix), .res(res));

	always #2 clk = ~clk;

	// Configuration copy held by the predictor, updated on each config transaction.
	logic [3:0]  cur_op = 4'(pia_pkg::OP_ADD);
	logic        cur_lic = 1'b0;
	logic [31:0] cur_const = '0;

	pix_result_t pending_results[$];
	// Bit 33 marks a typed row, bit 32 is its flag, the low bits its value.
	logic [33:0] typed_values[$];
	int unsigned mismatches = 0;
	logic        zero_gaps = 1'b0;

	// Floor of the square root of a 64-bit unsigned value.
	function automatic logic [63:0] root_floor(input logic [63:0] n);
		logic [63:0] rem, root, bitv;
		rem = n;
		root = '0;
		bitv = 64'h4000000000000000;
		while (bitv > rem) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// Expected ALU output for one pair of pixels under the current configuration.
	function automatic pix_result_t alu_result(input logic [31:0] lraw, input logic [31:0] rraw);
		logic signed [127:0] l, r, v;
		logic [63:0] lm, rm, prod;
		logic negv, sat;
		pix_result_t o;
		l = $signed(cur_lic ? cur_const : lraw);
		r = $signed(rraw);
		lm = l[127] ? 64'(-l) : 64'(l);
		rm = r[127] ? 64'(-r) : 64'(r);
		negv = l[127] != r[127];
		sat = 1'b0;
		v = '0;
		case (cur_op)
			pia_pkg::OP_ADD: v = l + r;
			pia_pkg::OP_SUB: v = l - r;
			pia_pkg::OP_MUL: begin
				prod = (lm * rm) >> pia_pkg::FracBits;
				v = negv ? -$signed({64'd0, prod}) : $signed({64'd0, prod});
			end
			pia_pkg::OP_DIV: begin
				if (r == 0) begin
					sat = 1'b1;
					v = (l == 0) ? 128'sd0 : (l < 0 ? -128'sd2147483648 : 128'sd2147483647);
				end else begin
					prod = (lm << pia_pkg::FracBits) / rm;
					v = negv ? -$signed({64'd0, prod}) : $signed({64'd0, prod});
				end
			end
			pia_pkg::OP_ABSDIFF: begin
				v = l - r;
				if (v < 0) v = -v;
			end
			pia_pkg::OP_NORM: v = $signed({64'd0, root_floor(lm * lm + rm * rm)});
			pia_pkg::OP_MIN: v = (l < r) ? l : r;
			pia_pkg::OP_MAX: v = (r < l) ? l : r;
			pia_pkg::OP_LT: v = (l < r) ? 128'sd65536 : 128'sd0;
			pia_pkg::OP_GT: v = (r < l) ? 128'sd65536 : 128'sd0;
			pia_pkg::OP_EQ: v = (l == r) ? 128'sd65536 : 128'sd0;
			default: v = '0;
		endcase
		if (v > 128'sd2147483647) begin
			v = 128'sd2147483647;
			sat = 1'b1;
		end else if (v < -128'sd2147483648) begin
			v = -128'sd2147483648;
			sat = 1'b1;
		end
		o.value = v[31:0];
		o.sat = sat;
		return o;
	endfunction

	// Track config writes, predict accepted pairs and check delivered results.
	always @(posedge clk) begin
		pix_result_t got, want;
		logic [33:0] typed;
		if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				pia_pkg::REG_OPERATION: cur_op = cfg.data[3:0];
				pia_pkg::REG_LEFT_IS_CONSTANT: cur_lic = cfg.data[0];
				pia_pkg::REG_LEFT_CONSTANT: cur_const = cfg.data;
				default: ;
			endcase
		end
		if (pix.valid && pix.ready) begin
			typed = typed_values.pop_front();
			if (typed[33]) pending_results.push_back('{typed[31:0], typed[32]});
			else pending_results.push_back(alu_result(pix.left_pixel, pix.right_pixel));
		end
		if (res.valid && res.ready) begin
			got.value = res.result_pixel;
			got.sat = res.saturated;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h sat %b", got.value, got.sat);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h sat %b, got %h sat %b",
							want.value, want.sat, got.value, got.sat);
				end
			end
		end
	end

	// Result side: random stalls, with no stall while zero_gaps is set.
	initial begin
		int unsigned w;
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			w = zero_gaps ? 0 : $urandom_range(0, 12);
			if (w > 0) begin
				res.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
		end
	end

	task automatic write_reg(input pia_pkg::reg_idx_t idx, input logic [31:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
	endtask

	// Wait until the pipeline drains, then load all three registers.
	task automatic configure(input logic [3:0] op, input logic lic, input logic [31:0] k);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (Latency + 8) @(posedge clk);
		write_reg(pia_pkg::REG_OPERATION, {28'd0, op});
		write_reg(pia_pkg::REG_LEFT_IS_CONSTANT, {31'd0, lic});
		write_reg(pia_pkg::REG_LEFT_CONSTANT, k);
		cfg.valid <= 1'b0;
	endtask

	task automatic send_pair(input logic [31:0] l, input logic [31:0] r, input logic typed,
			input logic [31:0] value, input logic sat);
		int unsigned g;
		g = zero_gaps ? 0 : $urandom_range(0, 12);
		if (g > 0) begin
			pix.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		typed_values.push_back({typed, sat, value});
		pix.valid <= 1'b1;
		pix.left_pixel <= l;
		pix.right_pixel <= r;
		do @(posedge clk); while (!pix.ready);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return WordMax;
			1: return WordMin;
			2: return 32'd0;
			3: return $urandom_range(0, 1) ? 32'($urandom_range(0, 1 << 20))
				: -32'($urandom_range(0, 1 << 20));
			4: return OneQ * 32'($urandom_range(0, 8)) * ($urandom_range(0, 1) ? 32'd1 : -32'd1);
			default: return $urandom;
		endcase
	endfunction

	// Directed rows: extremes, every operation and the special cases.
	row_t rows[] = '{
		'{4'(pia_pkg::OP_ADD), 0, 0, WordMax, 32'd1, 1, WordMax, 1},
		'{4'(pia_pkg::OP_ADD), 0, 0, WordMin, WordMin, 1, WordMin, 1},
		'{4'(pia_pkg::OP_ADD), 0, 0, 32'd5, 32'd7, 1, 32'd12, 0},
		'{4'(pia_pkg::OP_SUB), 0, 0, WordMin, 32'd1, 1, WordMin, 1},
		'{4'(pia_pkg::OP_SUB), 0, 0, WordMax, WordMin, 1, WordMax, 1},
		'{4'(pia_pkg::OP_MUL), 0, 0, WordMax, WordMax, 1, WordMax, 1},
		'{4'(pia_pkg::OP_MUL), 0, 0, WordMin, WordMax, 0, 0, 0},
		'{4'(pia_pkg::OP_MUL), 0, 0, 32'hfffe8000, 32'h00018000, 0, 0, 0},
		'{4'(pia_pkg::OP_DIV), 0, 0, 32'd5, 32'd0, 1, WordMax, 1},
		'{4'(pia_pkg::OP_DIV), 0, 0, WordMin, 32'd0, 1, WordMin, 1},
		'{4'(pia_pkg::OP_DIV), 0, 0, 32'd0, 32'd0, 1, 32'd0, 1},
		'{4'(pia_pkg::OP_DIV), 0, 0, WordMin, 32'hffff0000, 1, WordMax, 1},
		'{4'(pia_pkg::OP_DIV), 0, 0, 32'hfffffffd, 32'h00020000, 0, 0, 0},
		'{4'(pia_pkg::OP_ABSDIFF), 0, 0, WordMin, WordMax, 1, WordMax, 1},
		'{4'(pia_pkg::OP_NORM), 0, 0, WordMin, WordMin, 1, WordMax, 1},
		'{4'(pia_pkg::OP_NORM), 0, 0, 32'd3, 32'hfffffffc, 1, 32'd5, 0},
		'{4'(pia_pkg::OP_MIN), 0, 0, WordMin, WordMax, 1, WordMin, 0},
		'{4'(pia_pkg::OP_MAX), 0, 0, WordMin, WordMax, 1, WordMax, 0},
		'{4'(pia_pkg::OP_LT), 0, 0, WordMin, WordMax, 1, OneQ, 0},
		'{4'(pia_pkg::OP_GT), 0, 0, WordMin, WordMax, 1, 32'd0, 0},
		'{4'(pia_pkg::OP_EQ), 0, 0, 32'd9, 32'd9, 1, OneQ, 0},
		'{4'(pia_pkg::OP_EQ), 1, WordMin, 32'd0, WordMin, 1, OneQ, 0},
		'{4'(pia_pkg::OP_SUB), 1, WordMax, 32'd1, 32'hffffffff, 1, WordMax, 1},
		'{4'(pia_pkg::OP_EQ) + 4'd1, 0, 0, WordMax, WordMax, 1, 32'd0, 0},
		'{4'(pia_pkg::OP_EQ) + 4'd5, 1, 32'h12345678, WordMin, WordMax, 1, 32'd0, 0}
	};

	// Main stimulus: reset, directed table, then random phases.
	initial begin
		logic [3:0]  op;
		logic [31:0] l, r;
		int unsigned n;
		cfg.valid <= 1'b0;
		cfg.index <= '0;
		cfg.data <= '0;
		pix.valid <= 1'b0;
		pix.left_pixel <= '0;
		pix.right_pixel <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Reset state is add on the left pixel.
		send_pair(32'd3, 32'd4, 1, 32'd7, 0);
		foreach (rows[i]) begin
			if (i == 0 || rows[i].op != rows[i-1].op || rows[i].lic != rows[i-1].lic
					|| rows[i].konst != rows[i-1].konst) begin
				pix.valid <= 1'b0;
				@(posedge clk);
				configure(rows[i].op, rows[i].lic, rows[i].konst);
			end
			send_pair(rows[i].l, rows[i].r, rows[i].typed, rows[i].value, rows[i].sat);
		end
		n = 0;
		while (n < 1550) begin
			pix.valid <= 1'b0;
			@(posedge clk);
			op = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(11, 15))
				: 4'($urandom_range(0, 10));
			configure(op, 1'($urandom_range(0, 1)), pick_word());
			zero_gaps = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(60, 140)) begin
				l = pick_word();
				r = ($urandom_range(0, 7) == 0) ? (cur_lic ? cur_const : l) : pick_word();
				send_pair(l, r, 0, 0, 0);
				n++;
			end
			zero_gaps = 1'b0;
		end
		pix.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (Latency + 8) @(posedge clk);
		if (mismatches == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

	// Safety net against a hung handshake.
	initial begin
		#4000000;
		$display("testbench: done, errors");
		$finish;
	end
endmodule
